>>> rtl/bzh_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bzh_pkg: shared types and constants of the board Zobrist hash block
// Sizes of the board, piece kind codes, command codes and the record that
// moves along the row of square cells.
// ----------------------------------------------------------------------------
package bzh_pkg;

  localparam int SQUARES     = 32;
  localparam int PIECE_KINDS = 4;
  localparam int KIND_W      = $clog2(PIECE_KINDS);
  localparam int KEY_W       = 64;
  localparam int BOARD_W     = 32;
  localparam int SQ_W        = 5;

  localparam int IN_DATA_W  = 328;
  localparam int OUT_DATA_W = 128;

  typedef logic [KIND_W-1:0]  kind_t;
  typedef logic [KEY_W-1:0]   key_t;
  typedef logic [SQUARES-1:0] mask_t;

  localparam kind_t KIND_BMAN  = kind_t'(0);
  localparam kind_t KIND_WMAN  = kind_t'(1);
  localparam kind_t KIND_BKING = kind_t'(2);
  localparam kind_t KIND_WKING = kind_t'(3);

  typedef enum logic [1:0] {
    CMD_LOAD = 2'd0,
    CMD_HASH = 2'd1,
    CMD_MOVE = 2'd2,
    CMD_NONE = 2'd3
  } cmd_t;

  typedef enum logic {
    REG_SIDE_KEY   = 1'b0,
    REG_PROMO_MASK = 1'b1
  } reg_index_t;

  // Record handed from cell to cell. Square masks shift down one place per
  // cell so that each cell looks at bit 0 only.
  typedef struct packed {
    mask_t                   load_sel;
    kind_t                   load_kind;
    key_t                    load_key;
    logic [PIECE_KINDS-1:0][SQUARES-1:0] occ;
    mask_t                   to_sel;
    kind_t                   to_kind;
    mask_t                   from_sel;
    kind_t                   from_kind;
    key_t                    acc;
    logic                    has_result;
    logic                    is_move;
    logic                    black;
    key_t                    cur_key;
  } item_t;

endpackage

>>> rtl/bzh_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bzh_cell: one square of the hash chain
// Holds the keys of its square for every piece kind, folds the selected keys
// into the running XOR and hands the item to the next square.
// ----------------------------------------------------------------------------
module bzh_cell (
  input  logic          clk,
  input  logic          rst,
  input  logic          advance,
  input  logic          in_valid,
  input  bzh_pkg::item_t in_item,
  output logic          out_valid,
  output bzh_pkg::item_t out_item
);
  import bzh_pkg::*;

  key_t  keys [PIECE_KINDS];
  key_t  acc_next;
  item_t item_next;

  always_comb begin
    acc_next = in_item.acc;
    for (int k = 0; k < PIECE_KINDS; k++) begin
      if (in_item.occ[k][0]) begin
        acc_next = acc_next ^ keys[k];
      end
    end
    if (in_item.to_sel[0]) begin
      acc_next = acc_next ^ keys[in_item.to_kind];
    end
    if (in_item.from_sel[0]) begin
      acc_next = acc_next ^ keys[in_item.from_kind];
    end

    item_next          = in_item;
    item_next.acc      = acc_next;
    item_next.load_sel = in_item.load_sel >> 1;
    item_next.to_sel   = in_item.to_sel >> 1;
    item_next.from_sel = in_item.from_sel >> 1;
    for (int k = 0; k < PIECE_KINDS; k++) begin
      item_next.occ[k] = in_item.occ[k] >> 1;
    end
  end

  // Key storage: written by a load item passing this square
  always_ff @(posedge clk) begin
    if (advance && in_valid && in_item.load_sel[0]) begin
      keys[in_item.load_kind] <= in_item.load_key;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item <= item_next;
    end
  end

endmodule

>>> rtl/board_zobrist_hash.sv
`timescale 1ns / 1ps
// Each item passes through the row of square cells and then the output register.
// Throughput: one item per cycle; the whole chain holds while the output waits.
// Load items and unknown commands give no result.
// Reset clears valid flags and configuration (side key 0, promotion mask
// 0xF000000F); the key storage inside the cells keeps its contents.
// ----------------------------------------------------------------------------
// board_zobrist_hash: Zobrist hash of a checkers board
// Decodes each item into per-square masks, runs it through a row of square
// cells that fold in their keys, and finishes with the side key.
// ----------------------------------------------------------------------------
module board_zobrist_hash (
  input  logic                              clk,
  input  logic                              rst,
  // Input items
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // tdata from bit 0: square(5), piece_kind(2), key_value(64), black_pieces(32),
  // white_pieces(32), king_pieces(32), black_to_move(1), move_from(32),
  // move_to(32), move_captures(32), current_key(64)
  input  logic [bzh_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // tuser: command(2)
  input  logic [1:0]                        s_axis_tuser,
  // Result items
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // tdata from bit 0: hash_value(64), updated_key(64)
  output logic [bzh_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  // Configuration writes
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic                              cfg_index,
  input  logic [63:0]                       cfg_data
);
  import bzh_pkg::*;

  // Configuration registers
  key_t               side_key;
  logic [BOARD_W-1:0] promo_mask;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      side_key   <= '0;
      promo_mask <= 32'hF000_000F;
    end else if (cfg_valid) begin
      case (reg_index_t'(cfg_index))
        REG_SIDE_KEY:   side_key   <= cfg_data;
        REG_PROMO_MASK: promo_mask <= cfg_data[BOARD_W-1:0];
        default: ;
      endcase
    end
  end

  // Unpack the input item
  cmd_t               cmd;
  logic [SQ_W-1:0]    in_square;
  kind_t              in_kind;
  key_t               in_key;
  logic [BOARD_W-1:0] bp, wp, kp, mv_from, mv_to, caps;
  logic               in_black;
  key_t               in_cur;

  assign cmd       = cmd_t'(s_axis_tuser);
  assign in_square = s_axis_tdata[4:0];
  assign in_kind   = s_axis_tdata[6:5];
  assign in_key    = s_axis_tdata[70:7];
  assign bp        = s_axis_tdata[102:71];
  assign wp        = s_axis_tdata[134:103];
  assign kp        = s_axis_tdata[166:135];
  assign in_black  = s_axis_tdata[167];
  assign mv_from   = s_axis_tdata[199:168];
  assign mv_to     = s_axis_tdata[231:200];
  assign caps      = s_axis_tdata[263:232];
  assign in_cur    = s_axis_tdata[327:264];

  // Decode the item into square masks for the chain
  item_t              entry;
  logic [BOARD_W-1:0] from_low, to_low;
  logic               from_king, promote;
  kind_t              man_k, king_k, opp_man_k, opp_king_k;

  always_comb begin
    // Isolate the lowest set bit of each move mask
    from_low   = mv_from & (~mv_from + BOARD_W'(1));
    to_low     = mv_to & (~mv_to + BOARD_W'(1));
    from_king  = |(mv_from & kp);
    promote    = |(mv_to & promo_mask);
    man_k      = in_black ? KIND_BMAN  : KIND_WMAN;
    king_k     = in_black ? KIND_BKING : KIND_WKING;
    opp_man_k  = in_black ? KIND_WMAN  : KIND_BMAN;
    opp_king_k = in_black ? KIND_WKING : KIND_BKING;

    entry            = '0;
    entry.load_kind  = in_kind;
    entry.load_key   = in_key;
    entry.black      = in_black;
    entry.cur_key    = in_cur;
    entry.to_kind    = (from_king || promote) ? king_k : man_k;
    entry.from_kind  = from_king ? king_k : man_k;
    entry.has_result = 1'b0;
    entry.is_move    = 1'b0;

    case (cmd)
      CMD_LOAD: begin
        entry.load_sel = mask_t'(1) << in_square;
      end
      CMD_HASH: begin
        entry.has_result      = 1'b1;
        entry.occ[KIND_BKING] = mask_t'(bp & kp);
        entry.occ[KIND_BMAN]  = mask_t'(bp & ~kp);
        entry.occ[KIND_WKING] = mask_t'(wp & kp);
        entry.occ[KIND_WMAN]  = mask_t'(wp & ~kp);
      end
      CMD_MOVE: begin
        entry.has_result       = 1'b1;
        entry.is_move          = 1'b1;
        entry.to_sel           = mask_t'(to_low);
        entry.from_sel         = mask_t'(from_low);
        entry.occ[opp_king_k]  = mask_t'(caps & kp);
        entry.occ[opp_man_k]   = mask_t'(caps & ~kp);
      end
      default: ;
    endcase
  end

  // Advance the chain whenever the output register is free or being drained
  logic advance;
  assign advance       = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = advance;

  // Row of square cells; stage 0 takes the decoded input directly
  logic  stage_valid [SQUARES+1];
  item_t stage_item  [SQUARES+1];

  assign stage_valid[0] = s_axis_tvalid;
  assign stage_item[0]  = entry;

  for (genvar s = 0; s < SQUARES; s++) begin : g_cell
    bzh_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .advance   (advance),
      .in_valid  (stage_valid[s]),
      .in_item   (stage_item[s]),
      .out_valid (stage_valid[s+1]),
      .out_item  (stage_item[s+1])
    );
  end

  // Finish: side key into updated key for moves, hash for black to move; form result, drop no-result items
  item_t last;
  key_t  hash_next, upd_next;

  assign last = stage_item[SQUARES];

  always_comb begin
    if (last.is_move) begin
      hash_next = last.acc;
      upd_next  = last.cur_key ^ last.acc ^ side_key;
    end else begin
      hash_next = last.black ? (last.acc ^ side_key) : last.acc;
      upd_next  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= stage_valid[SQUARES] && last.has_result;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_axis_tdata <= {upd_next, hash_next};
    end
  end

endmodule
